// ===== sv/lefc_pkg.sv =====
// ----------------------------------------------------------------------------
// lefc_pkg
// Shared types, constants and the bytewise CRC-32 update for the log entry
// framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lefc_pkg;

    // Parameter defaults
    localparam int MAX_PAYLOAD_DEF  = 64;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int ADDRESS_BITS_DEF = 24;

    // Fixed field widths
    localparam int FIELD_ADDR_W = 24;
    localparam int LEN_W        = 8;
    localparam int BYTE_W       = 8;
    localparam int CRC_W        = 32;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Record overhead around the payload: magic header (0xDEADBEEF, implied),
    // length word and CRC word.
    localparam int HEADER_BYTES   = 4;
    localparam int OVERHEAD_BYTES = 12;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ONES = 32'hFFFF_FFFF;

    // Register index (word address bit)
    localparam logic REG_INITIAL_HEAD = 1'b0;

    typedef enum logic {
        KIND_BYTE    = 1'b0,
        KIND_TRAILER = 1'b1
    } kind_t;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_TOO_LONG = 1'b1
    } status_t;

    // Trailer beat held in the result stage
    typedef struct packed {
        logic [FIELD_ADDR_W-1:0] entry_address;
        logic [LEN_W-1:0]        stored_length;
        logic [CRC_W-1:0]        crc_value;
        logic                    crosses_sector;
        status_t                 status;
    } trailer_t;

    // Reflected CRC-32, one byte: eight shift/xor steps
    function automatic logic [CRC_W-1:0] crc32_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] b
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/log_entry_framer_crc32_core.sv =====
// ----------------------------------------------------------------------------
// log_entry_framer_crc32_core
// Frames append-only flash log records: payload byte writes plus a trailer
// with entry start, length, CRC-32, a sector crossing flag and a status.
// ----------------------------------------------------------------------------
// A result beat is registered and shows in the cycle after its input is accepted.
// Throughput: one input beat per cycle while result_ready is high; the final byte
//   of an entry yields two result beats (byte, trailer), so the entry side pauses
//   there until the byte beat is taken. After a head register write the entry side
//   holds ready low while a reciprocal multiply finds head modulo SECTOR_BYTES
//   (quotient, then remainder). Head wrapping past the top of the address space
//   costs nothing. Reset (rst_n, async, active low): head 0, CRC all ones, no entry
//   open, no result pending, sector offset 0 (no remainder pass needed).
`default_nettype none

module log_entry_framer_crc32_core
    import lefc_pkg::*;
#(
    parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic      [APB_DATA_W-1:0]   prdata,
    output logic                         pready,
    // entry byte channel
    input  wire logic                    entry_valid,
    output logic                         entry_ready,
    input  wire logic [LEN_W-1:0]        entry_length,
    input  wire logic [BYTE_W-1:0]       data_byte,
    // result channel
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output logic                         kind,
    output logic [FIELD_ADDR_W-1:0]      write_address,
    output logic [BYTE_W-1:0]            out_byte,
    output logic [FIELD_ADDR_W-1:0]      entry_address,
    output logic [LEN_W-1:0]             stored_length,
    output logic [CRC_W-1:0]             crc_value,
    output logic                         crosses_sector,
    output logic                         status,
    output logic                         last
);

    localparam int AW         = ADDRESS_BITS;
    localparam int RECORD     = MAX_PAYLOAD + OVERHEAD_BYTES;
    localparam int OFF_W      = $clog2(SECTOR_BYTES);
    localparam int SUM_W      = OFF_W + 2;
    localparam int HEAD_SUM_W = AW + 1;
    localparam int PROD_W     = 2 * AW + 1;

    // Sector size reciprocal, rounded up: exact quotient for every head value
    localparam longint unsigned RECIP_L =
        ((64'd1 << (AW + OFF_W)) + 64'(SECTOR_BYTES) - 64'd1) / 64'(SECTOR_BYTES);
    // Sector offset of the top of the address space, dropped when head wraps
    localparam longint unsigned WRAP_L = (64'd1 << AW) % 64'(SECTOR_BYTES);

    localparam logic [SUM_W-1:0]      SECTOR_S   = SUM_W'(SECTOR_BYTES);
    localparam logic [SUM_W-1:0]      RECORD_S   = SUM_W'(RECORD);
    localparam logic [SUM_W-1:0]      RECLAST_S  = SUM_W'(RECORD - 1);
    localparam logic [SUM_W-1:0]      WRAP_S     = SUM_W'(WRAP_L);
    localparam logic [AW:0]           RECIP      = (AW+1)'(RECIP_L);
    localparam logic [OFF_W-1:0]      SECTOR_LOW = OFF_W'(SECTOR_BYTES);
    localparam logic [HEAD_SUM_W-1:0] RECORD_H   = HEAD_SUM_W'(RECORD);
    localparam logic [AW-1:0]         HEADER_A   = AW'(HEADER_BYTES);
    localparam logic [LEN_W-1:0]      MAX_LEN    = LEN_W'(MAX_PAYLOAD);

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic [FIELD_ADDR_W-1:0] init_head_reg;
    logic                    cfg_wr;
    logic                    head_wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign head_wr = cfg_wr & (paddr[2] == REG_INITIAL_HEAD);

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_INITIAL_HEAD)
        begin
            prdata = APB_DATA_W'(init_head_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_head_reg <= '0;
        end
        else if (head_wr)
        begin
            init_head_reg <= pwdata[FIELD_ADDR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Entry state
    // ------------------------------------------------------------------
    logic [AW-1:0]     head_reg,    head_next;
    logic [OFF_W-1:0]  off_reg,     off_next;      // head modulo sector size
    logic [CRC_W-1:0]  crc_reg,     crc_next;
    logic [LEN_W-1:0]  count_reg,   count_next;
    logic [LEN_W-1:0]  latched_reg, latched_next;
    logic              open_reg,    open_next;
    logic              long_reg,    long_next;

    // remainder unit: quotient phase, then remainder phase
    logic              busy_reg,    busy_next;
    logic              phase_reg,   phase_next;
    logic [AW-1:0]     quot_reg,    quot_next;

    // result stage: byte slot shown ahead of trailer slot
    logic              bv_reg,      bv_next;
    logic [FIELD_ADDR_W-1:0] baddr_reg, baddr_next;
    logic [BYTE_W-1:0] bbyte_reg,   bbyte_next;
    logic              blast_reg,   blast_next;
    logic              tv_reg,      tv_next;
    trailer_t          trl_reg,     trl_next;

    // ------------------------------------------------------------------
    // Per-beat datapath
    // ------------------------------------------------------------------
    logic              accept;
    logic              deliver;
    logic              first;
    logic              zero_len;
    logic [LEN_W-1:0]  cur_len;
    logic              cur_long;
    logic [LEN_W-1:0]  cur_count;
    logic [CRC_W-1:0]  cur_crc;
    logic [CRC_W-1:0]  crc_byte_upd;
    logic [CRC_W-1:0]  crc_after;
    logic [LEN_W-1:0]  count_inc;
    logic              byte_ev;
    logic              trl_ev;
    logic [AW-1:0]     byte_addr;
    logic [HEAD_SUM_W-1:0] head_sum;
    logic              head_wraps;
    logic [SUM_W-1:0]  off_sum;
    logic [SUM_W-1:0]  off_sub1;
    logic [SUM_W-1:0]  off_sub2;
    logic [SUM_W-1:0]  off_wrap;
    logic              crosses;
    logic [PROD_W-1:0] recip_prod;
    logic [2*OFF_W-1:0] back_prod;
    logic [OFF_W-1:0]  head_rem;

    // Accept while no remainder pass runs and the result stage is empty or drains its last beat now.
    assign entry_ready = !busy_reg
                         && ((!bv_reg && !tv_reg)
                             || (result_ready && (bv_reg ^ tv_reg)));
    assign accept      = entry_valid & entry_ready;
    assign deliver     = result_valid & result_ready;

    // First beat of an entry samples its length and restarts the CRC.
    assign first     = !open_reg;
    assign zero_len  = first && (entry_length == '0);
    assign cur_len   = first ? entry_length : latched_reg;
    assign cur_long  = first ? (entry_length > MAX_LEN) : long_reg;
    assign cur_count = first ? '0 : count_reg;
    assign cur_crc   = first ? CRC_ONES : crc_reg;

    assign crc_byte_upd = crc32_byte(cur_crc, data_byte);
    assign byte_ev      = !zero_len && !cur_long;
    assign crc_after    = byte_ev ? crc_byte_upd : cur_crc;
    assign count_inc    = cur_count + LEN_W'(1);
    assign trl_ev       = zero_len || (count_inc == cur_len);

    assign byte_addr = head_reg + HEADER_A + AW'(cur_count);

    // Head advance and wrap past the top of the address space
    assign head_sum   = HEAD_SUM_W'(head_reg) + RECORD_H;
    assign head_wraps = head_sum[AW];

    // Sector test on the unwrapped record end: offset + record - 1 >= sector
    assign crosses  = (SUM_W'(off_reg) + RECLAST_S) >= SECTOR_S;
    assign off_sum  = SUM_W'(off_reg) + RECORD_S;
    assign off_sub1 = (off_sum  >= SECTOR_S) ? (off_sum  - SECTOR_S) : off_sum;
    assign off_sub2 = (off_sub1 >= SECTOR_S) ? (off_sub1 - SECTOR_S) : off_sub1;
    // on a wrap, take away the sector offset of the top of the space
    assign off_wrap = (off_sub2 >= WRAP_S) ? (off_sub2 - WRAP_S)
                                           : (off_sub2 + SECTOR_S - WRAP_S);

    // Head modulo sector size: quotient by reciprocal, then low bits of
    // head - quotient * sector, which is below the sector size
    assign recip_prod = PROD_W'(head_reg) * PROD_W'(RECIP);
    assign back_prod  = (2*OFF_W)'(quot_reg[OFF_W-1:0]) * (2*OFF_W)'(SECTOR_LOW);
    assign head_rem   = head_reg[OFF_W-1:0] - back_prod[OFF_W-1:0];

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        head_next    = head_reg;
        off_next     = off_reg;
        crc_next     = crc_reg;
        count_next   = count_reg;
        latched_next = latched_reg;
        open_next    = open_reg;
        long_next    = long_reg;
        busy_next    = busy_reg;
        phase_next   = phase_reg;
        quot_next    = quot_reg;

        // advance the remainder unit
        if (busy_reg)
        begin
            if (!phase_reg)
            begin
                quot_next  = AW'(recip_prod >> (AW + OFF_W));
                phase_next = 1'b1;
            end
            else
            begin
                off_next   = head_rem;
                busy_next  = 1'b0;
                phase_next = 1'b0;
            end
        end

        if (head_wr)
        begin
            // abandon any open entry and reload head
            head_next    = AW'(pwdata[FIELD_ADDR_W-1:0]);
            off_next     = '0;
            crc_next     = CRC_ONES;
            count_next   = '0;
            latched_next = '0;
            open_next    = 1'b0;
            long_next    = 1'b0;
            busy_next    = 1'b1;
            phase_next   = 1'b0;
        end
        else if (accept)
        begin
            if (trl_ev)
            begin
                crc_next     = CRC_ONES;
                count_next   = '0;
                latched_next = '0;
                open_next    = 1'b0;
                long_next    = 1'b0;
                if (!cur_long)
                begin
                    head_next = head_sum[AW-1:0];
                    if (head_wraps)
                    begin
                        off_next = off_wrap[OFF_W-1:0];
                    end
                    else
                    begin
                        off_next = off_sub2[OFF_W-1:0];
                    end
                end
            end
            else
            begin
                crc_next     = crc_after;
                count_next   = count_inc;
                latched_next = cur_len;
                open_next    = 1'b1;
                long_next    = cur_long;
            end
        end
    end

    // Result stage
    always_comb
    begin
        bv_next    = bv_reg;
        tv_next    = tv_reg;
        baddr_next = baddr_reg;
        bbyte_next = bbyte_reg;
        blast_next = blast_reg;
        trl_next   = trl_reg;

        // drop the beat taken this cycle: byte slot first
        if (deliver)
        begin
            if (bv_reg)
            begin
                bv_next = 1'b0;
            end
            else
            begin
                tv_next = 1'b0;
            end
        end

        if (accept)
        begin
            bv_next    = byte_ev;
            tv_next    = trl_ev;
            baddr_next = FIELD_ADDR_W'(byte_addr);
            bbyte_next = data_byte;
            blast_next = !trl_ev;
            trl_next.entry_address  = FIELD_ADDR_W'(head_reg);
            trl_next.stored_length  = cur_len;
            trl_next.crc_value      = cur_long ? '0 : ~crc_after;
            trl_next.crosses_sector = cur_long ? 1'b0 : crosses;
            trl_next.status         = cur_long ? STATUS_TOO_LONG : STATUS_OK;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            off_reg     <= '0;
            crc_reg     <= CRC_ONES;
            count_reg   <= '0;
            latched_reg <= '0;
            open_reg    <= 1'b0;
            long_reg    <= 1'b0;
            busy_reg    <= 1'b0;
            phase_reg   <= 1'b0;
            quot_reg    <= '0;
            bv_reg      <= 1'b0;
            tv_reg      <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            off_reg     <= off_next;
            crc_reg     <= crc_next;
            count_reg   <= count_next;
            latched_reg <= latched_next;
            open_reg    <= open_next;
            long_reg    <= long_next;
            busy_reg    <= busy_next;
            phase_reg   <= phase_next;
            quot_reg    <= quot_next;
            bv_reg      <= bv_next;
            tv_reg      <= tv_next;
        end
    end

    // payload of the result stage needs no reset
    always_ff @(posedge clk)
    begin
        baddr_reg <= baddr_next;
        bbyte_reg <= bbyte_next;
        blast_reg <= blast_next;
        trl_reg   <= trl_next;
    end

    // ------------------------------------------------------------------
    // Result beat: byte slot if held, else the trailer
    // ------------------------------------------------------------------
    always_comb
    begin
        result_valid   = bv_reg | tv_reg;
        write_address  = '0;
        out_byte       = '0;
        entry_address  = '0;
        stored_length  = '0;
        crc_value      = '0;
        crosses_sector = 1'b0;
        status         = STATUS_OK;
        if (bv_reg)
        begin
            kind          = KIND_BYTE;
            write_address = baddr_reg;
            out_byte      = bbyte_reg;
            last          = blast_reg;
        end
        else
        begin
            kind           = KIND_TRAILER;
            entry_address  = trl_reg.entry_address;
            stored_length  = trl_reg.stored_length;
            crc_value      = trl_reg.crc_value;
            crosses_sector = trl_reg.crosses_sector;
            status         = trl_reg.status;
            last           = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lefc_checker.sv =====
// ----------------------------------------------------------------------------
// lefc_checker
// Port-level checks for the log entry framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lefc_checker
    import lefc_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    result_valid,
    input wire logic                    result_ready,
    input wire logic                    kind,
    input wire logic [FIELD_ADDR_W-1:0] write_address,
    input wire logic [BYTE_W-1:0]       out_byte,
    input wire logic [LEN_W-1:0]        stored_length,
    input wire logic [CRC_W-1:0]        crc_value,
    input wire logic                    crosses_sector,
    input wire logic                    status,
    input wire logic                    last
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(kind) && $stable(write_address)
            && $stable(out_byte) && $stable(crc_value) && $stable(last))
    else $error("result beat changed while stalled");

    // A byte beat that is not last is followed at once by its trailer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && (kind == KIND_BYTE) && !last |=>
            result_valid && (kind == KIND_TRAILER))
    else $error("trailer missing after final byte");

    // A dropped entry reports no CRC and no flush
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_TRAILER) && (status == STATUS_TOO_LONG) |->
            (crc_value == '0) && !crosses_sector)
    else $error("too-long trailer carries CRC or flush");

    // An empty entry has the inverted initial CRC
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == KIND_TRAILER) && (status == STATUS_OK)
            && (stored_length == '0) |-> (crc_value == '0))
    else $error("empty entry CRC not zero");

endmodule

bind log_entry_framer_crc32_core lefc_checker u_lefc_checker (.*);

`default_nettype wire

// ===== verif/log_entry_framer_crc32_checker.sv =====
// ----------------------------------------------------------------------------
// log_entry_framer_crc32_checker
// Watches the configuration port and both beat channels of the log entry
// framer. It predicts every result beat and compares each accepted one,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module log_entry_framer_crc32_checker
    import lefc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    input  wire logic [APB_DATA_W-1:0]   prdata,
    input  wire logic                    pready,
    input  wire logic                    entry_valid,
    input  wire logic                    entry_ready,
    input  wire logic [LEN_W-1:0]        entry_length,
    input  wire logic [BYTE_W-1:0]       data_byte,
    input  wire logic                    result_valid,
    input  wire logic                    result_ready,
    input  wire logic                    kind,
    input  wire logic [FIELD_ADDR_W-1:0] write_address,
    input  wire logic [BYTE_W-1:0]       out_byte,
    input  wire logic [FIELD_ADDR_W-1:0] entry_address,
    input  wire logic [LEN_W-1:0]        stored_length,
    input  wire logic [CRC_W-1:0]        crc_value,
    input  wire logic                    crosses_sector,
    input  wire logic                    status,
    input  wire logic                    last,
    output int                           mismatch_count,
    output int                           pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned RECORD_BYTES = MAX_PAYLOAD_DEF + OVERHEAD_BYTES;

    typedef struct packed {
        kind_t                   kind;
        logic [FIELD_ADDR_W-1:0] write_address;
        logic [BYTE_W-1:0]       out_byte;
        logic [FIELD_ADDR_W-1:0] entry_address;
        logic [LEN_W-1:0]        stored_length;
        logic [CRC_W-1:0]        crc_value;
        logic                    crosses_sector;
        status_t                 status;
        logic                    last;
    } framer_beat_t;

    framer_beat_t                expected_beats[$];

    logic [FIELD_ADDR_W-1:0]     head_reg;
    logic [ADDRESS_BITS_DEF-1:0] head;
    logic [CRC_W-1:0]            crc_acc;
    logic [LEN_W-1:0]            bytes_seen;
    logic [LEN_W-1:0]            entry_len;
    logic                        open_entry;
    logic                        dropping;

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ CRC_W'(b);
        repeat (8)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    task automatic clear_entry();
        crc_acc    = CRC_ONES;
        bytes_seen = '0;
        entry_len  = '0;
        open_entry = 1'b0;
        dropping   = 1'b0;
    endtask

    // Close the record: trailer beat, head advance unless the entry is dropped
    task automatic push_trailer();
        framer_beat_t    t;
        longint unsigned first_addr;
        longint unsigned end_addr;
        t               = '0;
        t.kind          = KIND_TRAILER;
        t.entry_address = FIELD_ADDR_W'(head);
        t.stored_length = entry_len;
        t.last          = 1'b1;
        if (dropping)
        begin
            t.status = STATUS_TOO_LONG;
        end
        else
        begin
            t.status         = STATUS_OK;
            t.crc_value      = ~crc_acc;
            first_addr       = 64'(head);
            end_addr         = first_addr + RECORD_BYTES - 1;
            t.crosses_sector = (first_addr / SECTOR_BYTES_DEF) != (end_addr / SECTOR_BYTES_DEF);
            head             = ADDRESS_BITS_DEF'(head + RECORD_BYTES);
        end
        expected_beats.push_back(t);
        clear_entry();
    endtask

    task automatic frame_beat(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] b);
        framer_beat_t w;
        w = '0;
        if (!open_entry)
        begin
            crc_acc    = CRC_ONES;
            bytes_seen = '0;
            entry_len  = len;
            dropping   = (len > MAX_PAYLOAD_DEF);
            if (len == '0)
            begin
                push_trailer();
                return;
            end
            open_entry = 1'b1;
        end
        if (!dropping)
        begin
            w.kind          = KIND_BYTE;
            w.status        = STATUS_OK;
            w.write_address = FIELD_ADDR_W'(ADDRESS_BITS_DEF'(head + HEADER_BYTES + bytes_seen));
            w.out_byte      = b;
            crc_acc         = crc_step(crc_acc, b);
        end
        bytes_seen = bytes_seen + 1'b1;
        if (bytes_seen == entry_len)
        begin
            if (!dropping)
            begin
                expected_beats.push_back(w);
            end
            push_trailer();
        end
        else if (!dropping)
        begin
            w.last = 1'b1;
            expected_beats.push_back(w);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_beat();
        framer_beat_t want;
        if (expected_beats.size() == 0)
        begin
            $error("result beat with nothing expected: kind %0d last %0d", kind, last);
            mismatch_count++;
            return;
        end
        want = expected_beats.pop_front();
        check_field("kind", want.kind, kind);
        check_field("write_address", want.write_address, write_address);
        check_field("out_byte", want.out_byte, out_byte);
        check_field("entry_address", want.entry_address, entry_address);
        check_field("stored_length", want.stored_length, stored_length);
        check_field("crc_value", want.crc_value, crc_value);
        check_field("crosses_sector", want.crosses_sector, crosses_sector);
        check_field("status", want.status, status);
        check_field("last", want.last, last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_beats.delete();
            head_reg        = '0;
            head            = '0;
            clear_entry();
            mismatch_count  = 0;
            pending_results = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:2] == REG_INITIAL_HEAD)
            begin
                if (pwrite)
                begin
                    // a head load abandons whatever entry is open
                    head_reg = pwdata[FIELD_ADDR_W-1:0];
                    head     = ADDRESS_BITS_DEF'(head_reg);
                    clear_entry();
                end
                else
                begin
                    check_field("prdata", head_reg, prdata[FIELD_ADDR_W-1:0]);
                end
            end
            if (result_valid && result_ready)
            begin
                compare_beat();
            end
            if (entry_valid && entry_ready)
            begin
                frame_beat(entry_length, data_byte);
            end
            pending_results = expected_beats.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the log entry framer with directed and random log entries through
// its entry channel and head register, stalls the result channel at random,
// and reports the verdict from the checker's mismatch and pending-result counts.
// ----------------------------------------------------------------------------
module testbench;
    import lefc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Register map: head register at word 0, word 1 is unmapped
    localparam logic [APB_ADDR_W-1:0] HEAD_ADDR     = {REG_INITIAL_HEAD, 2'b00};
    localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_INITIAL_HEAD, 2'b00};

    localparam int RECORD_BYTES  = MAX_PAYLOAD_DEF + OVERHEAD_BYTES;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int CONFIG_EVERY  = 120;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    entry_valid;
    logic                    entry_ready;
    logic [LEN_W-1:0]        entry_length;
    logic [BYTE_W-1:0]       data_byte;
    logic                    result_valid;
    logic                    result_ready;
    logic                    kind;
    logic [FIELD_ADDR_W-1:0] write_address;
    logic [BYTE_W-1:0]       out_byte;
    logic [FIELD_ADDR_W-1:0] entry_address;
    logic [LEN_W-1:0]        stored_length;
    logic [CRC_W-1:0]        crc_value;
    logic                    crosses_sector;
    logic                    status;
    logic                    last;

    int                      mismatch_count;
    int                      pending_results;

    int                      items_sent;
    bit                      tx_quiet;
    bit                      rx_quiet;
    // bytes to use ahead of random ones, for directed entries
    logic [BYTE_W-1:0]       byte_plan[$];

    log_entry_framer_crc32_core u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .entry_valid    (entry_valid),
        .entry_ready    (entry_ready),
        .entry_length   (entry_length),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .kind           (kind),
        .write_address  (write_address),
        .out_byte       (out_byte),
        .entry_address  (entry_address),
        .stored_length  (stored_length),
        .crc_value      (crc_value),
        .crosses_sector (crosses_sector),
        .status         (status),
        .last           (last)
    );

    log_entry_framer_crc32_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .entry_valid     (entry_valid),
        .entry_ready     (entry_ready),
        .entry_length    (entry_length),
        .data_byte       (data_byte),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .kind            (kind),
        .write_address   (write_address),
        .out_byte        (out_byte),
        .entry_address   (entry_address),
        .stored_length   (stored_length),
        .crc_value       (crc_value),
        .crosses_sector  (crosses_sector),
        .status          (status),
        .last            (last),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: give up well past the slowest legal run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    // Idle draw shared by both sides; a quiet stretch means back-to-back beats
    function automatic int draw_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // Register write: setup cycle, then access cycle until pready.
    // Call at a falling edge with the entry side idle.
    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register read; the checker compares prdata on the access edge
    task automatic reg_read(input logic [APB_ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one entry beat and hold it until accepted. Valid is left high on
    // return so that a following beat with no gap keeps it up; settle() drops it.
    task automatic send_beat(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] b);
        int gap;
        gap = draw_wait(tx_quiet);
        if (gap > 0)
        begin
            entry_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        entry_valid  <= 1'b1;
        entry_length <= len;
        data_byte    <= b;
        do @(posedge clk); while (!entry_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Send an entry of len payload bytes. cut > 0 stops after cut beats and
    // leaves the entry open. Only the first beat's length is sampled, so
    // scramble it on later beats half of the time.
    task automatic send_entry(input logic [LEN_W-1:0] len, input int cut);
        int                beats;
        logic [LEN_W-1:0]  len_field;
        logic [BYTE_W-1:0] b;
        beats = (cut > 0) ? cut : ((len == '0) ? 1 : int'(len));
        for (int i = 0; i < beats; i++)
        begin
            len_field = (i == 0 || $urandom_range(0, 1) == 0) ? len : LEN_W'($urandom);
            b = (byte_plan.size() > 0) ? byte_plan.pop_front() : BYTE_W'($urandom);
            send_beat(len_field, b);
        end
    endtask

    // Drop valid, wait for every predicted result, then cover absorbed beats
    // still inside the block before touching the head register.
    task automatic settle();
        entry_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Entry lengths: mostly short, some empty, a few at or past the maximum
    function automatic logic [LEN_W-1:0] draw_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)       return '0;
        else if (r < 68) return LEN_W'($urandom_range(1, 8));
        else if (r < 86) return LEN_W'($urandom_range(9, MAX_PAYLOAD_DEF - 5));
        else if (r < 93) return LEN_W'($urandom_range(MAX_PAYLOAD_DEF - 4, MAX_PAYLOAD_DEF));
        else if (r < 97) return LEN_W'($urandom_range(MAX_PAYLOAD_DEF + 1, MAX_PAYLOAD_DEF + 8));
        else             return LEN_W'($urandom_range(MAX_PAYLOAD_DEF + 9, 255));
    endfunction

    // Head values: extremes, near the top of the address space (wraps), just
    // before a sector boundary, or anywhere. Upper data bits are noise.
    function automatic logic [APB_DATA_W-1:0] pick_head();
        logic [FIELD_ADDR_W-1:0]            h;
        logic [APB_DATA_W-FIELD_ADDR_W-1:0] spare;
        spare = $urandom;
        case ($urandom_range(0, 5))
            0:       h = '0;
            1:       h = '1;
            2:       h = '1 - FIELD_ADDR_W'($urandom_range(0, 160));
            3:       h = FIELD_ADDR_W'($urandom_range(1, 4095) * SECTOR_BYTES_DEF
                                       - $urandom_range(0, 90));
            default: h = FIELD_ADDR_W'($urandom);
        endcase
        return {spare, h};
    endfunction

    // Result side: draw a stall per beat, then hold ready until a beat moves
    initial
    begin
        int stall;
        result_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_wait(rx_quiet);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    // Main stimulus and verdict
    initial
    begin
        int               random_start;
        int               last_config;
        int               cut;
        logic [LEN_W-1:0] len;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        entry_valid  = 1'b0;
        entry_length = '0;
        data_byte    = '0;
        items_sent   = 0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;

        // hold reset low, then release it on a falling edge
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        reg_write(HEAD_ADDR, '0);
        reg_read(HEAD_ADDR);

        // empty entry: trailer alone, CRC of nothing, head still advances
        send_entry('0, 0);
        // single bytes at both extremes, then a two-byte entry
        byte_plan = '{8'h00};
        send_entry(8'd1, 0);
        byte_plan = '{8'hFF};
        send_entry(8'd1, 0);
        byte_plan = '{8'hFF, 8'h80};
        send_entry(8'd2, 0);

        // abandon an open entry by loading head near the top of the space
        send_entry(8'd5, 2);
        settle();
        reg_write(HEAD_ADDR, 32'h00FF_FFF0);
        // record runs past the top: flagged as crossing, head wraps
        send_entry('0, 0);

        // record ending on the last byte of a sector, then one that crosses
        settle();
        reg_write(HEAD_ADDR, APB_DATA_W'(SECTOR_BYTES_DEF - RECORD_BYTES));
        send_entry(8'd1, 0);
        settle();
        reg_write(HEAD_ADDR, APB_DATA_W'(SECTOR_BYTES_DEF - RECORD_BYTES + 1));
        send_entry('0, 0);

        // abandon a too-long entry mid-way; upper data bits must be dropped
        send_entry(8'(MAX_PAYLOAD_DEF + 6), 4);
        settle();
        reg_write(HEAD_ADDR, '1);
        // byte address wraps past the top
        byte_plan = '{8'h55};
        send_entry(8'd1, 0);

        // unmapped register: no effect on head
        settle();
        reg_write(UNMAPPED_ADDR, 32'h0000_1234);
        reg_read(HEAD_ADDR);

        // ---- random part ----
        random_start = items_sent;
        last_config  = items_sent;

        // open with the longest legal entry and two dropped ones
        send_entry(8'(MAX_PAYLOAD_DEF), 0);
        send_entry(8'(MAX_PAYLOAD_DEF + 1), 0);
        send_entry(8'd255, 0);

        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            tx_quiet = ($urandom_range(0, 6) == 0);
            rx_quiet = ($urandom_range(0, 6) == 0);
            len      = draw_length();

            if (len >= 2 && $urandom_range(0, 24) == 0)
            begin
                // broken entry: stop part way and reload head
                cut = $urandom_range(1, len - 1);
                send_entry(len, cut);
                settle();
                reg_write(HEAD_ADDR, pick_head());
                last_config = items_sent;
            end
            else
            begin
                send_entry(len, 0);
            end

            if (items_sent - last_config >= CONFIG_EVERY)
            begin
                settle();
                if ($urandom_range(0, 3) == 0)
                begin
                    reg_write(UNMAPPED_ADDR, $urandom);
                end
                reg_write(HEAD_ADDR, pick_head());
                reg_read(HEAD_ADDR);
                last_config = items_sent;
            end
        end

        // ---- drain and verdict ----
        tx_quiet = 1'b0;
        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== log_entry_framer_crc32_core.f =====
sv/lefc_pkg.sv
sv/log_entry_framer_crc32_core.sv
sv/lefc_checker.sv
verif/log_entry_framer_crc32_checker.sv
verif/testbench.sv
